// ===== rtl/dtp_pkg.sv =====
// dtp_pkg: types, codes and constants shared by the duration text parser.
// Used by dtp_parser, dtp_scale and duration_text_parser_unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_INT,
        PH_CLOCK,
        PH_AFTER_CLOCK,
        PH_FRAC
    } dtp_phase_t;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int FRAC_W      = 30;
    localparam int CLK_FIELD_W = 7;
    localparam int SEC_PER_H   = 3600;
    localparam int SEC_PER_MIN = 60;
    localparam logic [FRAC_W-1:0] NS_PER_S = 30'd1000000000;
    localparam int DUR_W       = 63;

    typedef struct packed {
        logic                   neg;
        logic                   hours;
        logic [CLK_FIELD_W-1:0] minutes;
        logic [CLK_FIELD_W-1:0] seconds;
        logic [FRAC_W-1:0]      frac;
        logic                   err;
    } dtp_snap_t;

    // weight in ns of the fraction digit at a given position (100 ms first)
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [3:0] pos);
        logic [FRAC_W-1:0] w;
        case (pos)
            4'd0:    w = 30'd100000000;
            4'd1:    w = 30'd10000000;
            4'd2:    w = 30'd1000000;
            4'd3:    w = 30'd100000;
            4'd4:    w = 30'd10000;
            4'd5:    w = 30'd1000;
            4'd6:    w = 30'd100;
            4'd7:    w = 30'd10;
            4'd8:    w = 30'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dtp_parser.sv =====
// dtp_parser: byte-wise grammar state machine and field accumulators.
// Hands a snapshot of the fields to the scaler on each final byte. Uses dtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtp_parser #(
    parameter int MAX_INT_DIGITS = 6
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   take,
    input  wire logic [7:0]                             char_code,
    input  wire logic                                   is_final,
    output logic                                        snap_valid,
    output dtp_pkg::dtp_snap_t                          snap,
    output logic [$clog2(longint'(10)**MAX_INT_DIGITS)-1:0] snap_lead
);
    import dtp_pkg::*;

    localparam int LEAD_W = $clog2(longint'(10)**MAX_INT_DIGITS);
    localparam int CNT_W  = $clog2(MAX_INT_DIGITS + 1);

    dtp_phase_t              phase_reg, phase_next, phase_load;
    logic                    neg_reg, neg_next;
    logic [LEAD_W-1:0]       lead_reg, lead_next;
    logic [CNT_W-1:0]        lead_cnt_reg, lead_cnt_next;
    logic                    hours_reg, hours_next;
    logic [2:0]              pos_reg, pos_next;
    logic [CLK_FIELD_W-1:0]  min_reg, min_next;
    logic [CLK_FIELD_W-1:0]  sec_reg, sec_next;
    logic [FRAC_W-1:0]       frac_reg, frac_next;
    logic [3:0]              frac_cnt_reg, frac_cnt_next;
    logic                    failed_reg, failed_next;

    logic       is_dig;
    logic [3:0] dig;
    logic       lead_room;
    logic       clock_ok;
    logic       frac_skip;
    logic       result_ok;

    assign is_dig    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign dig       = char_code[3:0];
    assign lead_room = lead_cnt_reg < CNT_W'(MAX_INT_DIGITS);
    assign clock_ok  = (pos_reg == 3'd2) ? (char_code == CH_COLON) : is_dig;
    assign frac_skip = ((frac_cnt_reg == 4'd3) || (frac_cnt_reg == 4'd6))
                       && (char_code == CH_UNDER);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (char_code == CH_MINUS)
                        phase_next = PH_SIGNED;
                    else if (is_dig && lead_room)
                        phase_next = PH_INT;
                end
                PH_SIGNED:
                begin
                    if (is_dig && lead_room)
                        phase_next = PH_INT;
                end
                PH_INT:
                begin
                    if (char_code == CH_COLON)
                        phase_next = PH_CLOCK;
                    else if (char_code == CH_DOT)
                        phase_next = PH_FRAC;
                end
                PH_CLOCK:
                begin
                    if (clock_ok && (pos_reg == 3'd4))
                        phase_next = PH_AFTER_CLOCK;
                end
                PH_AFTER_CLOCK:
                begin
                    if (char_code == CH_DOT)
                        phase_next = PH_FRAC;
                end
                PH_FRAC:
                    phase_next = PH_FRAC;
                default:
                    phase_next = PH_START;
            endcase
        end
    end

    // field updates
    always_comb
    begin
        neg_next      = neg_reg;
        lead_next     = lead_reg;
        lead_cnt_next = lead_cnt_reg;
        hours_next    = hours_reg;
        pos_next      = pos_reg;
        min_next      = min_reg;
        sec_next      = sec_reg;
        frac_next     = frac_reg;
        frac_cnt_next = frac_cnt_reg;
        failed_next   = failed_reg;
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_START, PH_SIGNED, PH_INT:
                begin
                    if (is_dig)
                    begin
                        if (lead_room)
                        begin
                            lead_next     = lead_reg * LEAD_W'(10) + LEAD_W'(dig);
                            lead_cnt_next = lead_cnt_reg + CNT_W'(1);
                        end
                        else
                            failed_next = 1'b1;
                    end
                    else if ((phase_reg == PH_START) && (char_code == CH_MINUS))
                        neg_next = 1'b1;
                    else if ((phase_reg == PH_INT) && (char_code == CH_COLON))
                        hours_next = 1'b1;
                    else if (!((phase_reg == PH_INT) && (char_code == CH_DOT)))
                        failed_next = 1'b1;
                end
                PH_CLOCK:
                begin
                    if (!clock_ok)
                        failed_next = 1'b1;
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_reg < 3'd2)
                            min_next = min_reg * CLK_FIELD_W'(10) + CLK_FIELD_W'(dig);
                        else if (pos_reg > 3'd2)
                            sec_next = sec_reg * CLK_FIELD_W'(10) + CLK_FIELD_W'(dig);
                    end
                end
                PH_AFTER_CLOCK:
                begin
                    if (char_code != CH_DOT)
                        failed_next = 1'b1;
                end
                PH_FRAC:
                begin
                    if (frac_cnt_reg >= 4'd9)
                        failed_next = 1'b1;
                    else if (!frac_skip)
                    begin
                        if (!is_dig)
                            failed_next = 1'b1;
                        else
                        begin
                            frac_next     = frac_reg + FRAC_W'(dig) * frac_weight(frac_cnt_reg);
                            frac_cnt_next = frac_cnt_reg + 4'd1;
                        end
                    end
                end
                default:
                    failed_next = 1'b1;
            endcase
        end
    end

    assign result_ok = !failed_next && ((phase_next == PH_INT)
                       || (phase_next == PH_AFTER_CLOCK) || (phase_next == PH_FRAC));

    assign phase_load   = is_final ? PH_START : phase_next;
    assign snap_valid   = take && is_final;
    assign snap.neg     = neg_next;
    assign snap.hours   = hours_next;
    assign snap.minutes = min_next;
    assign snap.seconds = sec_next;
    assign snap.frac    = frac_next;
    assign snap.err     = !result_ok;
    assign snap_lead    = lead_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            neg_reg      <= 1'b0;
            lead_reg     <= '0;
            lead_cnt_reg <= '0;
            hours_reg    <= 1'b0;
            pos_reg      <= '0;
            min_reg      <= '0;
            sec_reg      <= '0;
            frac_reg     <= '0;
            frac_cnt_reg <= '0;
            failed_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_load;
            if (is_final)
            begin
                neg_reg      <= 1'b0;
                lead_reg     <= '0;
                lead_cnt_reg <= '0;
                hours_reg    <= 1'b0;
                pos_reg      <= '0;
                min_reg      <= '0;
                sec_reg      <= '0;
                frac_reg     <= '0;
                frac_cnt_reg <= '0;
                failed_reg   <= 1'b0;
            end
            else
            begin
                neg_reg      <= neg_next;
                lead_reg     <= lead_next;
                lead_cnt_reg <= lead_cnt_next;
                hours_reg    <= hours_next;
                pos_reg      <= pos_next;
                min_reg      <= min_next;
                sec_reg      <= sec_next;
                frac_reg     <= frac_next;
                frac_cnt_reg <= frac_cnt_next;
                failed_reg   <= failed_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(phase_reg) && $stable(failed_reg) && $stable(lead_cnt_reg))
        else $error("parser state moved without a word");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_final |=> phase_reg == PH_START && !failed_reg && lead_cnt_reg == '0)
        else $error("parser not cleared after final byte");

    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lead_cnt_reg <= CNT_W'(MAX_INT_DIGITS))
        else $error("integer digit count past limit");

    a_hours_phase: assert property (@(posedge clk) disable iff (!rst_n)
        hours_reg |-> (phase_reg == PH_CLOCK || phase_reg == PH_AFTER_CLOCK
                       || phase_reg == PH_FRAC))
        else $error("hours form outside clock or fraction phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/dtp_scale.sv =====
// dtp_scale: converts a parsed snapshot to signed nanoseconds in three steps
// (total seconds, times 1e9, add fraction and sign into the result register) behind a snapshot register. Uses dtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtp_scale #(
    parameter int MAX_INT_DIGITS = 6
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   snap_valid,
    input  wire dtp_pkg::dtp_snap_t                     snap,
    input  wire logic [$clog2(longint'(10)**MAX_INT_DIGITS)-1:0] snap_lead,
    output logic                                        ready,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [dtp_pkg::DUR_W-1:0]            duration_ns,
    output logic                                        parse_error
);
    import dtp_pkg::*;

    localparam int LEAD_W  = $clog2(longint'(10)**MAX_INT_DIGITS);
    localparam longint TOT_MAX = (longint'(10)**MAX_INT_DIGITS - 1) * SEC_PER_H
                                 + 99 * SEC_PER_MIN + 99;
    localparam int TOT_W   = $clog2(TOT_MAX + 1);
    localparam int PROD_W  = TOT_W + FRAC_W;

    logic rdy1, rdy2, rdy3, rdy_out;

    logic              s1_valid_reg;
    dtp_snap_t         s1_snap_reg;
    logic [LEAD_W-1:0] s1_lead_reg;

    logic              s2_valid_reg;
    logic [TOT_W-1:0]  s2_tot_reg, s2_tot_next;
    logic [FRAC_W-1:0] s2_frac_reg;
    logic              s2_neg_reg, s2_err_reg;

    logic              s3_valid_reg;
    logic [PROD_W-1:0] s3_prod_reg, s3_prod_next;
    logic [FRAC_W-1:0] s3_frac_reg;
    logic              s3_neg_reg, s3_err_reg;

    logic              out_valid_reg;
    logic [DUR_W-1:0]  dur_reg, dur_next, mag;
    logic              err_reg;

    assign rdy_out = !out_valid_reg || !out_stall;
    assign rdy3    = !s3_valid_reg || rdy_out;
    assign rdy2    = !s2_valid_reg || rdy3;
    assign rdy1    = !s1_valid_reg || rdy2;
    assign ready   = rdy1;

    always_comb
    begin
        if (s1_snap_reg.hours)
            s2_tot_next = TOT_W'(s1_lead_reg) * TOT_W'(SEC_PER_H)
                        + TOT_W'(s1_snap_reg.minutes) * TOT_W'(SEC_PER_MIN)
                        + TOT_W'(s1_snap_reg.seconds);
        else
            s2_tot_next = TOT_W'(s1_lead_reg);
    end

    assign s3_prod_next = PROD_W'(s2_tot_reg) * PROD_W'(NS_PER_S);

    assign mag = DUR_W'(s3_prod_reg) + DUR_W'(s3_frac_reg);

    always_comb
    begin
        if (s3_err_reg)
            dur_next = '0;
        else if (s3_neg_reg)
            dur_next = '0 - mag;
        else
            dur_next = mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= snap_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy_out)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && snap_valid)
        begin
            s1_snap_reg <= snap;
            s1_lead_reg <= snap_lead;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_tot_reg  <= s2_tot_next;
            s2_frac_reg <= s1_snap_reg.frac;
            s2_neg_reg  <= s1_snap_reg.neg;
            s2_err_reg  <= s1_snap_reg.err;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_prod_reg <= s3_prod_next;
            s3_frac_reg <= s2_frac_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_err_reg  <= s2_err_reg;
        end
        if (rdy_out && s3_valid_reg)
        begin
            dur_reg <= dur_next;
            err_reg <= s3_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duration_ns = signed'(dur_reg);
    assign parse_error = err_reg;

endmodule

`default_nettype wire

// ===== rtl/duration_text_parser_unit.sv =====
// duration_text_parser_unit: top level of the duration text parser.
// Instantiates dtp_parser and dtp_scale; uses dtp_pkg.
//
//   channel | signals                         | word
//   --------+---------------------------------+------------------------------
//   in      | in_valid, in_stall              | char_code, is_final
//   out     | out_valid, out_stall            | duration_ns, parse_error
//
// One byte is taken per cycle while in_stall is low; the grammar state updates in the cycle it is taken.
// A final byte's word reaches the outputs through the snapshot register, then total
// seconds, multiply by 1e9, and fraction and sign added into the result register.
// Reset clears the parser state and all stage valid flags.
// in_stall rises only when all four stages hold words and out_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module duration_text_parser_unit #(
    parameter int MAX_INT_DIGITS = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         char_code,
    input  wire logic                               is_final,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [dtp_pkg::DUR_W-1:0]        duration_ns,
    output logic                                    parse_error
);
    import dtp_pkg::*;

    localparam int LEAD_W = $clog2(longint'(10)**MAX_INT_DIGITS);

    logic              ready;
    logic              take;
    logic              snap_valid;
    dtp_snap_t         snap;
    logic [LEAD_W-1:0] snap_lead;

    assign in_stall = !ready;
    assign take     = in_valid && ready;

    dtp_parser #(
        .MAX_INT_DIGITS (MAX_INT_DIGITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .char_code  (char_code),
        .is_final   (is_final),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_lead  (snap_lead)
    );

    dtp_scale #(
        .MAX_INT_DIGITS (MAX_INT_DIGITS)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_valid  (snap_valid),
        .snap        (snap),
        .snap_lead   (snap_lead),
        .ready       (ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duration_ns (duration_ns),
        .parse_error (parse_error)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while result path has room");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_error |-> duration_ns == '0)
        else $error("error word carries a non-zero duration");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(duration_ns) && $stable(parse_error))
        else $error("result word changed while stalled");
`endif

endmodule

`default_nettype wire
